// ===== hdl/token_context_compactor_top_assert.svh =====
// ----------------------------------------------------------------------------
// Token context compactor assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOKEN_CONTEXT_COMPACTOR_TOP_ASSERT_SVH
`define TOKEN_CONTEXT_COMPACTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TCC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tcc assertion failed");
`define TCC_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("tcc forbidden condition");
`else
`define TCC_ASSERT(lbl, prop)
`define TCC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== hdl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the token context compactor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int CAPACITY   = 4096;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int TOKEN_BITS = 32;
	localparam int SCORE_W    = 16;
	localparam int KEY_W      = SCORE_W + ADDR_W;
	localparam int FRAC_W     = 16;
	localparam int LIMIT_W    = 13;
	localparam int PROD_W     = LIMIT_W + FRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TOTAL_W    = 32;

	localparam logic [CNT_W-1:0]   CAP_COUNT  = CNT_W'(CAPACITY);
	localparam logic [SCORE_W-1:0] HALF_SCORE = SCORE_W'(16384);

	localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(4096);
	localparam logic [FRAC_W-1:0]  THRESH_RST    = FRAC_W'(58982);
	localparam logic [FRAC_W-1:0]  TARGET_RST    = FRAC_W'(32768);
	localparam logic [2:0]         STRATEGY_RST  = 3'd0;
	localparam logic               PRESERVE_RST  = 1'b1;
	localparam logic [LIMIT_W-1:0] PROMPT_RST    = LIMIT_W'(0);
	localparam logic [PROD_W-1:0]  THR_LIM_RST   = PROD_W'(4096 * 58982);
	localparam logic [CNT_W-1:0]   TLEN_RST      = CNT_W'((4096 * 32768) / 65536);

	typedef enum logic [1:0] {
		FUNC_APPEND    = 2'd0,
		FUNC_SET_SCORE = 2'd1,
		FUNC_RESET     = 2'd2,
		FUNC_READ      = 2'd3
	} func_t;

	localparam logic [2:0] STRAT_SLIDE   = 3'd0;
	localparam logic [2:0] STRAT_HALF    = 3'd1;
	localparam logic [2:0] STRAT_FIFO    = 3'd2;
	localparam logic [2:0] STRAT_IMPORT  = 3'd3;
	localparam logic [2:0] STRAT_SUMMARY = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESERVE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PROMPT   = 3'd5;

	typedef struct packed {
		logic [1:0]            func;
		logic [TOKEN_BITS-1:0] token_value;
		logic [11:0]           position;
		logic [SCORE_W-1:0]    score_value;
	} req_t;

	typedef struct packed {
		logic                  no_compaction;
		logic                  compacted;
		logic                  shift_valid;
		logic [12:0]           shift_offset;
		logic [12:0]           shift_length;
		logic [12:0]           token_count;
		logic [TOKEN_BITS-1:0] read_token;
		logic [SCORE_W-1:0]    read_score;
		logic                  in_range;
		logic                  store_full;
		logic [TOTAL_W-1:0]    compaction_total;
	} rsp_t;

	typedef struct packed {
		logic [2:0]         strategy;
		logic               preserve;
		logic [LIMIT_W-1:0] prompt;
		logic [PROD_W-1:0]  thr_lim;
		logic [CNT_W-1:0]   tlen;
	} cfg_t;

endpackage

// ===== hdl/token_context_compactor_top.sv =====
// ----------------------------------------------------------------------------
// token_context_compactor_top
// Token context store with threshold-triggered compaction.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request completes. The result appears on rsp for exactly one
// cycle with done high and cannot be held off by the receiver.
// Importance runs one scan of the n held entries per kept entry, bound by
// the single read port of the score and token RAMs.
// A new request may be taken in the cycle that carries done.
// Configuration writes (cfg_we, cfg_addr, cfg_data) are to be made only
// while the block is idle; the block itself does not enforce this. Reset
// empties the context, clears the compaction count and loads the default
// registers; store contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "token_context_compactor_top_assert.svh"

module token_context_compactor_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  tcc_pkg::req_t                       req,
	output logic                                busy,
	output logic                                done,
	output tcc_pkg::rsp_t                       rsp,
	input  logic                                cfg_we,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [tcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [tcc_pkg::LIMIT_W-1:0] limit_q;
	logic [tcc_pkg::FRAC_W-1:0]  thresh_q;
	logic [tcc_pkg::FRAC_W-1:0]  target_q;
	logic [2:0]                  strategy_q;
	logic                        preserve_q;
	logic [tcc_pkg::LIMIT_W-1:0] prompt_q;
	logic [tcc_pkg::PROD_W-1:0]  thr_lim_q;
	logic [tcc_pkg::CNT_W-1:0]   tlen_q;
	logic [tcc_pkg::PROD_W-1:0]  tgt_prod;
	tcc_pkg::cfg_t               cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= tcc_pkg::LIMIT_RST;
			thresh_q   <= tcc_pkg::THRESH_RST;
			target_q   <= tcc_pkg::TARGET_RST;
			strategy_q <= tcc_pkg::STRATEGY_RST;
			preserve_q <= tcc_pkg::PRESERVE_RST;
			prompt_q   <= tcc_pkg::PROMPT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				tcc_pkg::REG_LIMIT:    limit_q    <= cfg_data[tcc_pkg::LIMIT_W-1:0];
				tcc_pkg::REG_THRESH:   thresh_q   <= cfg_data;
				tcc_pkg::REG_TARGET:   target_q   <= cfg_data;
				tcc_pkg::REG_STRATEGY: strategy_q <= cfg_data[2:0];
				tcc_pkg::REG_PRESERVE: preserve_q <= cfg_data[0];
				tcc_pkg::REG_PROMPT:   prompt_q   <= cfg_data[tcc_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign tgt_prod = tcc_pkg::PROD_W'(limit_q) * tcc_pkg::PROD_W'(target_q);

	// register trigger product and target length after each multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_lim_q <= tcc_pkg::THR_LIM_RST;
			tlen_q    <= tcc_pkg::TLEN_RST;
		end else begin
			thr_lim_q <= tcc_pkg::PROD_W'(thresh_q) * tcc_pkg::PROD_W'(limit_q);
			tlen_q    <= tgt_prod[tcc_pkg::PROD_W-1:tcc_pkg::FRAC_W];
		end
	end

	always_comb begin
		cfg.strategy = strategy_q;
		cfg.preserve = preserve_q;
		cfg.prompt   = prompt_q;
		cfg.thr_lim  = thr_lim_q;
		cfg.tlen     = tlen_q;
	end

	tcc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.cfg    (cfg),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	`TCC_ASSERT(a_accept_busy, start && !busy |=> busy)
	`TCC_ASSERT(a_single_done, done |=> !done)
	`TCC_ASSERT_NEVER(a_flag_clash, done && rsp.compacted && (rsp.no_compaction || rsp.store_full))
	`TCC_ASSERT(a_shift_needs_compact, done && rsp.shift_valid |-> rsp.compacted)

endmodule

// ===== hdl/tcc_ram.sv =====
// ----------------------------------------------------------------------------
// tcc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcc_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/tcc_seq.sv =====
// ----------------------------------------------------------------------------
// tcc_seq
// Request sequencer: append, score update, read, and compaction passes
// over the token and score stores through one shared read/compare path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcc_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tcc_pkg::req_t req,
	input  tcc_pkg::cfg_t cfg,
	output logic          busy,
	output logic          done,
	output tcc_pkg::rsp_t rsp
);

	localparam int AW = tcc_pkg::ADDR_W;
	localparam int CW = tcc_pkg::CNT_W;
	localparam int TW = tcc_pkg::TOKEN_BITS;
	localparam int SW = tcc_pkg::SCORE_W;
	localparam int KW = tcc_pkg::KEY_W;
	localparam int EW = CW + 1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_CHECK = 8'b0000_0100,
		S_COPY  = 8'b0000_1000,
		S_SCAN  = 8'b0001_0000,
		S_PUT   = 8'b0010_0000,
		S_WB    = 8'b0100_0000,
		S_READ  = 8'b1000_0000
	} state_t;

	state_t                      state_q;
	tcc_pkg::req_t               req_q;
	tcc_pkg::rsp_t               rsp_q;
	logic                        done_q;
	logic [CW-1:0]               count_q;
	logic [tcc_pkg::TOTAL_W-1:0] total_q;
	logic [CW-1:0]               src_q;
	logic [CW-1:0]               end_q;
	logic [AW-1:0]               dst_q;
	logic [CW-1:0]               new_cnt_q;
	logic                        rv_s1;
	logic [AW-1:0]               dst_s1;
	logic [KW-1:0]               best_key_q;
	logic [TW-1:0]               best_tok_q;
	logic                        found_q;
	logic [KW-1:0]               prev_key_q;
	logic                        first_q;
	logic [CW-1:0]               d_q;

	logic          tok_we;
	logic          sc_we;
	logic [AW-1:0] st_waddr;
	logic [TW-1:0] tok_wd;
	logic [SW-1:0] sc_wd;
	logic [AW-1:0] st_raddr;
	logic [TW-1:0] tok_rd;
	logic [SW-1:0] sc_rd;
	logic          tmp_we;
	logic [AW-1:0] tmp_waddr;
	logic [AW-1:0] tmp_raddr;
	logic [TW+SW-1:0] tmp_wd;
	logic [TW+SW-1:0] tmp_rd;

	logic          pos_ok;
	logic          trig;
	logic          over;
	logic [CW-1:0] keep0;
	logic [CW-1:0] drop0;
	logic [CW-1:0] half_n;
	logic [CW-1:0] half_t;
	logic [CW-1:0] kp;
	logic [EW-1:0] ea;
	logic [EW-1:0] eb;
	logic [EW-1:0] ebc;
	logic          do_erase;
	logic          do_sel;
	logic          sv;
	logic [CW-1:0] soff;
	logic [KW-1:0] cand_key;
	logic          cand_win;

	tcc_ram #(.ADDR_W(AW), .DATA_W(TW)) u_tok_ram (
		.clk(clk), .we(tok_we), .waddr(st_waddr), .wdata(tok_wd),
		.raddr(st_raddr), .rdata(tok_rd)
	);

	tcc_ram #(.ADDR_W(AW), .DATA_W(SW)) u_sc_ram (
		.clk(clk), .we(sc_we), .waddr(st_waddr), .wdata(sc_wd),
		.raddr(st_raddr), .rdata(sc_rd)
	);

	tcc_ram #(.ADDR_W(AW), .DATA_W(TW + SW)) u_tmp_ram (
		.clk(clk), .we(tmp_we), .waddr(tmp_waddr), .wdata(tmp_wd),
		.raddr(tmp_raddr), .rdata(tmp_rd)
	);

	assign pos_ok = {1'b0, req_q.position} < count_q;
	assign trig   = {count_q, {tcc_pkg::FRAC_W{1'b0}}} > cfg.thr_lim;
	assign over   = count_q > cfg.tlen;
	assign half_n = count_q >> 1;
	assign half_t = cfg.tlen >> 1;
	assign drop0  = count_q - cfg.tlen;
	assign kp     = cfg.preserve ? cfg.prompt : '0;
	assign keep0  = !cfg.preserve ? '0 : ((cfg.prompt > half_t) ? cfg.prompt : half_t);

	always_comb begin
		ea       = '0;
		eb       = '0;
		do_erase = 1'b0;
		do_sel   = 1'b0;
		sv       = 1'b0;
		soff     = '0;
		if (over) begin
			case (cfg.strategy)
				tcc_pkg::STRAT_SLIDE: begin
					ea       = EW'(keep0);
					eb       = EW'(keep0) + ((keep0 >= drop0) ? '0 : EW'(drop0));
					do_erase = 1'b1;
					sv       = 1'b1;
					soff     = keep0;
				end
				tcc_pkg::STRAT_HALF: begin
					if (EW'(kp) + EW'(half_n) <= EW'(count_q)) begin
						ea       = EW'(kp);
						eb       = EW'(kp) + EW'(half_n);
						do_erase = 1'b1;
						sv       = 1'b1;
						soff     = kp;
					end
				end
				tcc_pkg::STRAT_FIFO: begin
					eb       = EW'(drop0);
					do_erase = 1'b1;
					sv       = 1'b1;
					soff     = drop0;
				end
				tcc_pkg::STRAT_IMPORT: begin
					do_sel = 1'b1;
					sv     = 1'b1;
				end
				tcc_pkg::STRAT_SUMMARY: begin
					eb       = EW'(half_n);
					do_erase = 1'b1;
				end
				default: begin
					do_erase = 1'b0;
				end
			endcase
		end
		ebc = (eb > EW'(count_q)) ? EW'(count_q) : eb;
		if (ea >= ebc) begin
			do_erase = 1'b0;
		end
	end

	assign cand_key = {sc_rd, ~dst_s1};
	assign cand_win = (first_q || cand_key < prev_key_q) && (!found_q || cand_key > best_key_q);

	always_comb begin
		tok_we    = 1'b0;
		sc_we     = 1'b0;
		st_waddr  = dst_s1;
		tok_wd    = tok_rd;
		sc_wd     = sc_rd;
		st_raddr  = src_q[AW-1:0];
		tmp_we    = 1'b0;
		tmp_waddr = d_q[AW-1:0];
		tmp_wd    = {best_tok_q, best_key_q[KW-1:AW]};
		tmp_raddr = src_q[AW-1:0];
		case (state_q)
			S_EXEC: begin
				st_raddr = req_q.position;
				if (req_q.func == tcc_pkg::FUNC_APPEND && count_q != tcc_pkg::CAP_COUNT) begin
					tok_we   = 1'b1;
					sc_we    = 1'b1;
					st_waddr = count_q[AW-1:0];
					tok_wd   = req_q.token_value;
					sc_wd    = tcc_pkg::HALF_SCORE;
				end else if (req_q.func == tcc_pkg::FUNC_SET_SCORE && pos_ok) begin
					sc_we    = 1'b1;
					st_waddr = req_q.position;
					sc_wd    = req_q.score_value;
				end
			end
			S_COPY: begin
				tok_we = rv_s1;
				sc_we  = rv_s1;
			end
			S_PUT: begin
				tmp_we = 1'b1;
			end
			S_WB: begin
				tok_we = rv_s1;
				sc_we  = rv_s1;
				tok_wd = tmp_rd[TW+SW-1:SW];
				sc_wd  = tmp_rd[SW-1:0];
			end
			default: begin
				tok_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
			total_q <= '0;
			rv_s1   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rv_s1  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						rsp_q   <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (tcc_pkg::func_t'(req_q.func))
						tcc_pkg::FUNC_APPEND: begin
							if (count_q == tcc_pkg::CAP_COUNT) begin
								rsp_q.store_full <= 1'b1;
								done_q           <= 1'b1;
								state_q          <= S_IDLE;
							end else begin
								count_q <= count_q + 1'b1;
								state_q <= S_CHECK;
							end
						end
						tcc_pkg::FUNC_SET_SCORE: begin
							rsp_q.in_range <= pos_ok;
							done_q         <= 1'b1;
							state_q        <= S_IDLE;
						end
						tcc_pkg::FUNC_RESET: begin
							count_q <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						default: begin
							if (pos_ok) begin
								rsp_q.in_range <= 1'b1;
								state_q        <= S_READ;
							end else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_READ: begin
					rsp_q.read_token <= tok_rd;
					rsp_q.read_score <= sc_rd;
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
				end
				S_CHECK: begin
					if (!trig) begin
						rsp_q.no_compaction <= 1'b1;
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						total_q            <= total_q + 1'b1;
						rsp_q.compacted    <= 1'b1;
						rsp_q.shift_valid  <= sv;
						rsp_q.shift_offset <= sv ? soff : '0;
						rsp_q.shift_length <= sv ? cfg.tlen : '0;
						if (do_sel && cfg.tlen == '0) begin
							count_q <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (do_sel) begin
							d_q     <= '0;
							src_q   <= '0;
							first_q <= 1'b1;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end else if (do_erase) begin
							src_q     <= ebc[CW-1:0];
							end_q     <= count_q;
							dst_q     <= ea[AW-1:0];
							new_cnt_q <= count_q - (ebc[CW-1:0] - ea[CW-1:0]);
							state_q   <= S_COPY;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_COPY: begin
					dst_s1 <= dst_q;
					if (src_q < end_q) begin
						rv_s1 <= 1'b1;
						src_q <= src_q + 1'b1;
						dst_q <= dst_q + 1'b1;
					end else if (!rv_s1) begin
						count_q <= new_cnt_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					dst_s1 <= src_q[AW-1:0];
					if (rv_s1 && cand_win) begin
						best_key_q <= cand_key;
						best_tok_q <= tok_rd;
						found_q    <= 1'b1;
					end
					if (src_q < count_q) begin
						rv_s1 <= 1'b1;
						src_q <= src_q + 1'b1;
					end else if (!rv_s1) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					prev_key_q <= best_key_q;
					first_q    <= 1'b0;
					found_q    <= 1'b0;
					src_q      <= '0;
					d_q        <= d_q + 1'b1;
					if (d_q + 1'b1 == cfg.tlen) begin
						end_q   <= cfg.tlen;
						dst_q   <= '0;
						state_q <= S_WB;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_WB: begin
					dst_s1 <= dst_q;
					if (src_q < end_q) begin
						rv_s1 <= 1'b1;
						src_q <= src_q + 1'b1;
						dst_q <= dst_q + 1'b1;
					end else if (!rv_s1) begin
						count_q <= end_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		rsp                  = rsp_q;
		rsp.token_count      = count_q;
		rsp.compaction_total = total_q;
	end

endmodule

// ===== sim/tb_token_context_compactor_top.sv =====
// ----------------------------------------------------------------------------
// tb_token_context_compactor_top
// Self-checking bench for the token context compactor. A directed table
// covers the field extremes, every request kind, every strategy and the
// corner cases, then random phases reconfigure the block and mix appends,
// score updates, reads and context clears. Responses are checked field by
// field against the table or a behavioral model of the context in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_token_context_compactor_top;

	localparam logic [2:0] STRAT_UNUSED = 3'd5;
	localparam int         IDLE_PCT[4] = '{0, 68, 68, 12};

	typedef struct {
		bit                            is_cfg;
		logic [tcc_pkg::CFG_IDX_W-1:0] idx;
		logic [15:0]                   val;
		tcc_pkg::req_t                 rq;
		bit                            typed;
		tcc_pkg::rsp_t                 want;
	} row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	tcc_pkg::req_t                  req = '0;
	logic                           busy;
	logic                           done;
	tcc_pkg::rsp_t                  rsp;
	logic                           cfg_we = 1'b0;
	logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [31:0]  ctx_tok[tcc_pkg::CAPACITY];
	logic [15:0]  ctx_score[tcc_pkg::CAPACITY];
	int unsigned  held;
	logic [31:0]  comp_runs;
	int unsigned  lim_r, thr_r, tgt_r, prompt_r;
	logic [2:0]   strat_r;
	bit           pres_r;

	tcc_pkg::rsp_t pending[$];
	row_t          plan[$];
	int            errors = 0;
	int            requests = 0;
	int            compactions_seen = 0;
	int            shifts_seen = 0;
	int            fulls_seen = 0;

	token_context_compactor_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#100ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void erase_span(int unsigned a, int unsigned b);
		int unsigned w;
		if (b > held) b = held;
		if (a >= b) return;
		w = b - a;
		for (int unsigned i = a; i + w < held; i++) begin
			ctx_tok[i]   = ctx_tok[i + w];
			ctx_score[i] = ctx_score[i + w];
		end
		held -= w;
	endfunction

	function automatic void keep_top_scores(int unsigned t);
		logic [31:0] tk;
		logic [15:0] sc;
		int          j;
		for (int i = 1; i < held; i++) begin
			tk = ctx_tok[i];
			sc = ctx_score[i];
			j = i - 1;
			while (j >= 0 && ctx_score[j] < sc) begin
				ctx_tok[j + 1]   = ctx_tok[j];
				ctx_score[j + 1] = ctx_score[j];
				j--;
			end
			ctx_tok[j + 1]   = tk;
			ctx_score[j + 1] = sc;
		end
		if (t < held) held = t;
	endfunction

	function automatic tcc_pkg::rsp_t predict_context(tcc_pkg::req_t r);
		tcc_pkg::rsp_t e;
		int unsigned   t, keep, drop, n;
		e = '0;
		case (tcc_pkg::func_t'(r.func))
			tcc_pkg::FUNC_APPEND: begin
				if (held >= tcc_pkg::CAPACITY) begin
					e.store_full = 1'b1;
				end else begin
					ctx_tok[held]   = r.token_value;
					ctx_score[held] = tcc_pkg::HALF_SCORE;
					held++;
					if (longint'(held) * 65536 > longint'(thr_r) * longint'(lim_r)) begin
						t = (lim_r * tgt_r) >> 16;
						n = held;
						e.compacted = 1'b1;
						if (strat_r <= tcc_pkg::STRAT_SUMMARY && n > t) begin
							case (strat_r)
								tcc_pkg::STRAT_SLIDE: begin
									keep = pres_r ? ((prompt_r > t / 2) ? prompt_r : t / 2) : 0;
									drop = n - t;
									if (keep >= drop) drop = 0;
									erase_span(keep, keep + drop);
									e.shift_valid = 1'b1;
									e.shift_offset = 13'(keep);
								end
								tcc_pkg::STRAT_HALF: begin
									drop = n / 2;
									keep = pres_r ? prompt_r : 0;
									if (keep + drop <= n) begin
										erase_span(keep, keep + drop);
										e.shift_valid = 1'b1;
										e.shift_offset = 13'(keep);
									end
								end
								tcc_pkg::STRAT_FIFO: begin
									erase_span(0, n - t);
									e.shift_valid = 1'b1;
									e.shift_offset = 13'(n - t);
								end
								tcc_pkg::STRAT_IMPORT: begin
									keep_top_scores(t);
									e.shift_valid = 1'b1;
								end
								default: erase_span(0, n / 2);
							endcase
							if (e.shift_valid) e.shift_length = 13'(t);
						end
						comp_runs++;
					end else begin
						e.no_compaction = 1'b1;
					end
				end
			end
			tcc_pkg::FUNC_SET_SCORE: begin
				if (r.position < held) begin
					ctx_score[r.position] = r.score_value;
					e.in_range = 1'b1;
				end
			end
			tcc_pkg::FUNC_RESET: held = 0;
			default: begin
				if (r.position < held) begin
					e.read_token = ctx_tok[r.position];
					e.read_score = ctx_score[r.position];
					e.in_range = 1'b1;
				end
			end
		endcase
		e.token_count = 13'(held);
		e.compaction_total = comp_runs;
		return e;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		tcc_pkg::rsp_t w;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				w = pending.pop_front();
				check_field("no_compaction", w.no_compaction, rsp.no_compaction);
				check_field("compacted", w.compacted, rsp.compacted);
				check_field("shift_valid", w.shift_valid, rsp.shift_valid);
				check_field("shift_offset", w.shift_offset, rsp.shift_offset);
				check_field("shift_length", w.shift_length, rsp.shift_length);
				check_field("token_count", w.token_count, rsp.token_count);
				check_field("read_token", w.read_token, rsp.read_token);
				check_field("read_score", w.read_score, rsp.read_score);
				check_field("in_range", w.in_range, rsp.in_range);
				check_field("store_full", w.store_full, rsp.store_full);
				check_field("compaction_total", w.compaction_total, rsp.compaction_total);
				compactions_seen += int'(rsp.compacted);
				shifts_seen += int'(rsp.shift_valid);
				fulls_seen += int'(rsp.store_full);
			end
		end
	end

	task automatic issue(tcc_pkg::req_t r, bit typed, tcc_pkg::rsp_t want);
		tcc_pkg::rsp_t e;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		e = predict_context(r);
		pending.insert(pending.size(), typed ? want : e);
		requests++;
	endtask

	task automatic hold_gap(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [tcc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tcc_pkg::REG_LIMIT:    lim_r = 32'(val & 16'h1FFF);
			tcc_pkg::REG_THRESH:   thr_r = 32'(val);
			tcc_pkg::REG_TARGET:   tgt_r = 32'(val);
			tcc_pkg::REG_STRATEGY: strat_r = val[2:0];
			tcc_pkg::REG_PRESERVE: pres_r = val[0];
			tcc_pkg::REG_PROMPT:   prompt_r = 32'(val & 16'h1FFF);
			default: ;
		endcase
	endtask

	function automatic tcc_pkg::req_t mk(tcc_pkg::func_t f, logic [31:0] tk, logic [11:0] pos,
			logic [15:0] sc);
		tcc_pkg::req_t r;
		r.func = f;
		r.token_value = tk;
		r.position = pos;
		r.score_value = sc;
		return r;
	endfunction

	function automatic void plan_cfg(logic [tcc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		row_t w;
		w = '{is_cfg: 1'b1, idx: idx, val: val, rq: '0, typed: 1'b0, want: '0};
		plan.insert(plan.size(), w);
	endfunction

	function automatic void plan_req(tcc_pkg::req_t r, bit typed, tcc_pkg::rsp_t want);
		row_t w;
		w = '{is_cfg: 1'b0, idx: '0, val: '0, rq: r, typed: typed, want: want};
		plan.insert(plan.size(), w);
	endfunction

	function automatic tcc_pkg::req_t random_request(int unsigned sel);
		logic [11:0] pos;
		logic [15:0] sc;
		pos = ($urandom_range(3) == 0 || held == 0) ? 12'($urandom)
			: 12'($urandom_range(held - 1));
		case ($urandom_range(3))
			0: sc = 16'($urandom);
			1: sc = 16'($urandom_range(3)) << 14;
			2: sc = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: sc = 16'($urandom_range(16383, 16385));
		endcase
		if (sel < 60) return mk(tcc_pkg::FUNC_APPEND, $urandom, 12'($urandom), sc);
		if (sel < 78) return mk(tcc_pkg::FUNC_SET_SCORE, $urandom, pos, sc);
		if (sel < 97) return mk(tcc_pkg::FUNC_READ, $urandom, pos, sc);
		return mk(tcc_pkg::FUNC_RESET, $urandom, 12'($urandom), sc);
	endfunction

	initial begin
		tcc_pkg::rsp_t w;
		int unsigned   lim;
		held = 0;
		comp_runs = '0;
		lim_r = 4096;
		thr_r = 58982;
		tgt_r = 32768;
		strat_r = tcc_pkg::STRAT_SLIDE;
		pres_r = 1'b1;
		prompt_r = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		plan_req(mk(tcc_pkg::FUNC_READ, '0, '0, '0), 1'b1, '0);
		plan_req(mk(tcc_pkg::FUNC_SET_SCORE, '0, '0, 16'hFFFF), 1'b1, '0);
		plan_req(mk(tcc_pkg::FUNC_RESET, '0, '0, '0), 1'b1, '0);
		w = '0; w.no_compaction = 1'b1; w.token_count = 13'd1;
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'hFFFF_FFFF, 12'hFFF, 16'hFFFF), 1'b1, w);
		w.token_count = 13'd2;
		plan_req(mk(tcc_pkg::FUNC_APPEND, '0, '0, '0), 1'b1, w);
		w = '0; w.read_token = 32'hFFFF_FFFF; w.read_score = tcc_pkg::HALF_SCORE;
		w.in_range = 1'b1; w.token_count = 13'd2;
		plan_req(mk(tcc_pkg::FUNC_READ, '0, '0, '0), 1'b1, w);
		w = '0; w.token_count = 13'd2;
		plan_req(mk(tcc_pkg::FUNC_READ, '0, 12'hFFF, '0), 1'b1, w);
		plan_req(mk(tcc_pkg::FUNC_SET_SCORE, '0, 12'd1, 16'hFFFF), 1'b0, '0);
		plan_req(mk(tcc_pkg::FUNC_SET_SCORE, '0, 12'd0, 16'h0000), 1'b0, '0);
		plan_req(mk(tcc_pkg::FUNC_READ, '0, 12'd1, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_LIMIT, 16'd4);
		plan_cfg(tcc_pkg::REG_THRESH, 16'd32768);
		plan_cfg(tcc_pkg::REG_TARGET, 16'd32768);
		plan_cfg(tcc_pkg::REG_STRATEGY, 16'(tcc_pkg::STRAT_IMPORT));
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'h1234_5678, '0, '0), 1'b0, '0);
		plan_req(mk(tcc_pkg::FUNC_READ, '0, 12'd0, '0), 1'b0, '0);
		plan_req(mk(tcc_pkg::FUNC_READ, '0, 12'd1, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_STRATEGY, 16'(tcc_pkg::STRAT_SLIDE));
		plan_cfg(tcc_pkg::REG_PRESERVE, 16'd0);
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'hA5A5_A5A5, '0, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_STRATEGY, 16'(tcc_pkg::STRAT_HALF));
		plan_cfg(tcc_pkg::REG_PRESERVE, 16'd1);
		plan_cfg(tcc_pkg::REG_PROMPT, 16'd1);
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'h5A5A_5A5A, '0, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_STRATEGY, 16'(tcc_pkg::STRAT_FIFO));
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'h0000_0001, '0, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_STRATEGY, 16'(tcc_pkg::STRAT_SUMMARY));
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'h8000_0000, '0, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_STRATEGY, 16'(STRAT_UNUSED));
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'h7FFF_FFFF, '0, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_LIMIT, 16'd0);
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'h0F0F_0F0F, '0, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_LIMIT, 16'd1);
		plan_cfg(tcc_pkg::REG_THRESH, 16'd0);
		plan_cfg(tcc_pkg::REG_TARGET, 16'd0);
		plan_cfg(tcc_pkg::REG_STRATEGY, 16'(tcc_pkg::STRAT_FIFO));
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'hF0F0_F0F0, '0, '0), 1'b0, '0);
		plan_cfg(tcc_pkg::REG_PROMPT, 16'd4096);
		plan_cfg(tcc_pkg::REG_TARGET, 16'hFFFF);
		plan_cfg(tcc_pkg::REG_THRESH, 16'hFFFF);
		plan_req(mk(tcc_pkg::FUNC_APPEND, 32'h0000_FFFF, '0, '0), 1'b0, '0);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				issue(plan[i].rq, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case ($urandom_range(3))
				0: lim = 1;
				1: lim = $urandom_range(2, 12);
				default: lim = $urandom_range(13, 40);
			endcase
			write_reg(tcc_pkg::REG_LIMIT, 16'(lim));
			write_reg(tcc_pkg::REG_THRESH, $urandom_range(3) == 0
				? 16'($urandom_range(1) * 16'hFFFF) : 16'($urandom_range(16384, 65535)));
			write_reg(tcc_pkg::REG_TARGET, $urandom_range(4) == 0
				? 16'($urandom_range(1) * 16'hFFFF) : 16'($urandom));
			write_reg(tcc_pkg::REG_STRATEGY, ph < 5 ? 16'(ph) : 16'($urandom_range(7)));
			write_reg(tcc_pkg::REG_PRESERVE, 16'($urandom_range(1)));
			write_reg(tcc_pkg::REG_PROMPT, $urandom_range(4) == 0
				? 16'd4096 : 16'($urandom_range(lim)));
			issue(mk(tcc_pkg::FUNC_RESET, $urandom, 12'($urandom), 16'($urandom)), 1'b0, '0);
			for (int k = 0; k < 53; k++) begin
				hold_gap(IDLE_PCT[ph % 4]);
				issue(random_request($urandom_range(99)), 1'b0, '0);
			end
		end

		drain();
		repeat (20) @(posedge clk);

		$display("Covered %0d requests over every strategy, idle patterns and reconfigurations.",
			requests);
		$display("Saw %0d compactions, %0d shift notices, %0d rejected appends.",
			compactions_seen, shifts_seen, fulls_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
